// ===== rtl/pmd2_pkg.sv =====
// Shared types, constants and the 2x2 mode function for the mode downscaler.
`default_nettype none

package pmd2_pkg;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_LEVELS = 4;
	localparam int MAX_HEIGHT     = 4096;

	localparam int PIX_W      = 16;
	localparam int SRC_W_W    = 11;
	localparam int SRC_H_W    = 13;
	localparam int LVL_CNT_W  = 3;
	localparam int ROW_W      = 12;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	localparam logic [SRC_W_W-1:0]   RST_SOURCE_WIDTH  = SRC_W_W'(1024);
	localparam logic [SRC_H_W-1:0]   RST_SOURCE_HEIGHT = SRC_H_W'(768);
	localparam logic [LVL_CNT_W-1:0] RST_LEVEL_COUNT   = LVL_CNT_W'(1);

	typedef logic [PIX_W-1:0] pixel_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SOURCE_WIDTH  = 2'd0,
		REG_SOURCE_HEIGHT = 2'd1,
		REG_LEVEL_COUNT   = 2'd2
	} cfg_index_t;

	// Pick the most frequent pixel of a 2x2 block, ties resolved a, b, c, d
	function automatic pixel_t mode_of_four(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
		pixel_t res;
		if (a == d || a == b || a == c) begin
			res = a;
		end else if (b == d || b == c) begin
			res = b;
		end else if (c == d) begin
			res = c;
		end else begin
			res = d;
		end
		return res;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/pmd2_level.sv =====
// One halving level: raster counters, pair line store and the 2x2 mode pick.
`default_nettype none

module pmd2_level #(
	parameter int LEVEL     = 0,
	parameter int MAX_WIDTH = pmd2_pkg::DEF_MAX_WIDTH
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 adv,
	input  wire logic                                 clear,
	input  wire logic                                 in_vld,
	input  wire pmd2_pkg::pixel_t                     in_pix,
	input  wire logic [$clog2(MAX_WIDTH+1)-1:0]       img_w,
	input  wire logic [pmd2_pkg::SRC_H_W-1:0]         img_h,
	output logic                                      out_vld_q,
	output pmd2_pkg::pixel_t                          out_pix_q,
	output logic                                      out_last_q
);
	import pmd2_pkg::*;

	localparam int WW    = $clog2(MAX_WIDTH + 1);
	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int DEPTH = ((MAX_WIDTH >> (LEVEL + 1)) > 0) ? (MAX_WIDTH >> (LEVEL + 1)) : 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [CW-1:0]      col_q;
	logic [ROW_W-1:0]   row_q;
	pixel_t             top_q;
	pixel_t             left_q;
	logic [2*PIX_W-1:0] rd_q;
	logic [2*PIX_W-1:0] mem [DEPTH];

	logic          step;
	logic          col_wrap;
	logic          row_wrap;
	logic          in_area;
	logic          even_row;
	logic          even_col;
	logic          pass;
	logic [AW-1:0] addr;

	// Decode the raster position of the incoming transaction
	assign step     = adv & in_vld;
	assign col_wrap = (WW'(col_q) + WW'(1)) >= img_w;
	assign row_wrap = (SRC_H_W'(row_q) + SRC_H_W'(1)) >= img_h;
	assign in_area  = (WW'(col_q) < {img_w[WW-1:1], 1'b0}) &&
	                  (SRC_H_W'(row_q) < {img_h[SRC_H_W-1:1], 1'b0});
	assign even_row = ~row_q[0];
	assign even_col = ~col_q[0];
	assign pass     = in_area & ~even_row & ~even_col;
	assign addr     = AW'(col_q >> 1);

	// Advance the column and row counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (step) begin
			if (col_wrap) begin
				col_q <= '0;
				row_q <= row_wrap ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Hold the top-left and bottom-left pixels of the pair being built
	always_ff @(posedge clk) begin
		if (step && in_area && even_col) begin
			if (even_row) begin
				top_q <= in_pix;
			end else begin
				left_q <= in_pix;
			end
		end
	end

	// Store the top pair on the even row, fetch it at the start of the odd-row pair
	always_ff @(posedge clk) begin
		if (step && in_area && even_row && !even_col) begin
			mem[addr] <= {in_pix, top_q};
		end
		if (step && in_area && !even_row && even_col) begin
			rd_q <= mem[addr];
		end
	end

	// Register the result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= in_vld & pass;
		end
	end

	// Register the picked pixel and the end-of-frame mark
	always_ff @(posedge clk) begin
		if (step && pass) begin
			out_pix_q  <= mode_of_four(rd_q[PIX_W-1:0], rd_q[2*PIX_W-1:PIX_W], left_q, in_pix);
			out_last_q <= ((WW'(col_q[CW-1:1]) + WW'(1)) == (img_w >> 1)) &&
			              ((SRC_H_W'(row_q[ROW_W-1:1]) + SRC_H_W'(1)) == (img_h >> 1));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/pixel_mode_downscale_2x2.sv =====
// Cascaded 2x2 mode downscaler for a raster stream of 16-bit pixels.
//
// Source pixels enter on in_valid/in_ready/pixel_in in raster order. Each
// level halves the image by picking the mode of every 2x2 block; an odd last
// column or row is dropped. Results of the last configured level leave on
// out_valid/out_ready/pixel_out, with frame_end high on the frame's last pixel.
// Configuration writes go through cfg_valid/cfg_index/cfg_data; cfg_ready is
// always high. A write to a known register restarts the frame.
// Throughput is one pixel per clock unless the receiver stalls. A result passes
// through one input register, then one registered stage for each of L levels,
// where L is level_count clamped to 1..MAX_LEVELS; each level has
// its own line store read and write once per cycle.
// Reset clears counters and valid flags and loads 1024 x 768, one level.
// Line store contents are undefined after reset and are always written first.
// When the receiver stalls with a result waiting, the whole pipe holds and
// in_ready drops until the result is taken.
`default_nettype none

module pixel_mode_downscale_2x2 #(
	parameter int MAX_WIDTH  = pmd2_pkg::DEF_MAX_WIDTH,
	parameter int MAX_LEVELS = pmd2_pkg::DEF_MAX_LEVELS
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [pmd2_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [pmd2_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire pmd2_pkg::pixel_t                    pixel_in,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output pmd2_pkg::pixel_t                         pixel_out,
	output logic                                     frame_end
);
	import pmd2_pkg::*;

	localparam int WW = $clog2(MAX_WIDTH + 1);
	localparam int LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;

	logic [SRC_W_W-1:0]   source_width_q;
	logic [SRC_H_W-1:0]   source_height_q;
	logic [LVL_CNT_W-1:0] level_count_q;
	logic                 clear;

	logic          adv;
	logic          vld_s0;
	pixel_t        pix_s0;
	logic [WW-1:0] w0;
	logic [SRC_H_W-1:0] h0;
	logic [LW-1:0] sel;

	logic          lvl_vld  [MAX_LEVELS+1];
	pixel_t        lvl_pix  [MAX_LEVELS+1];
	logic          lvl_last [MAX_LEVELS];

	assign cfg_ready = 1'b1;

	// Write configuration registers; a known index restarts the frame
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			source_width_q  <= RST_SOURCE_WIDTH;
			source_height_q <= RST_SOURCE_HEIGHT;
			level_count_q   <= RST_LEVEL_COUNT;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:  source_width_q  <= cfg_data[SRC_W_W-1:0];
				REG_SOURCE_HEIGHT: source_height_q <= cfg_data[SRC_H_W-1:0];
				REG_LEVEL_COUNT:   level_count_q   <= cfg_data[LVL_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		clear = 1'b0;
		if (cfg_valid) begin
			case (cfg_index)
				REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_LEVEL_COUNT: clear = 1'b1;
				default: clear = 1'b0;
			endcase
		end
	end

	// Clamp the frame size and the level count
	assign w0 = (32'(source_width_q) > MAX_WIDTH) ? WW'(MAX_WIDTH) : WW'(source_width_q);
	assign h0 = (32'(source_height_q) > MAX_HEIGHT) ? SRC_H_W'(MAX_HEIGHT) : source_height_q;

	always_comb begin
		if (level_count_q == '0) begin
			sel = '0;
		end else if (32'(level_count_q) > MAX_LEVELS) begin
			sel = LW'(MAX_LEVELS - 1);
		end else begin
			sel = LW'(level_count_q - LVL_CNT_W'(1));
		end
	end

	// Advance the whole pipe unless a result waits on a stalled receiver
	assign adv      = ~out_valid | out_ready;
	assign in_ready = adv;

	// Capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else if (adv) begin
			vld_s0 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && in_valid) begin
			pix_s0 <= pixel_in;
		end
	end

	assign lvl_vld[0] = vld_s0;
	assign lvl_pix[0] = pix_s0;

	// Chain the halving levels
	for (genvar l = 0; l < MAX_LEVELS; l++) begin : g_level
		logic [WW-1:0]      img_w;
		logic [SRC_H_W-1:0] img_h;

		assign img_w = w0 >> l;
		assign img_h = h0 >> l;

		pmd2_level #(
			.LEVEL     (l),
			.MAX_WIDTH (MAX_WIDTH)
		) u_level (
			.clk        (clk),
			.arst_n     (arst_n),
			.adv        (adv),
			.clear      (clear),
			.in_vld     (lvl_vld[l]),
			.in_pix     (lvl_pix[l]),
			.img_w      (img_w),
			.img_h      (img_h),
			.out_vld_q  (lvl_vld[l+1]),
			.out_pix_q  (lvl_pix[l+1]),
			.out_last_q (lvl_last[l])
		);
	end

	// Emit the last configured level
	assign out_valid = lvl_vld[32'(sel) + 1];
	assign pixel_out = lvl_pix[32'(sel) + 1];
	assign frame_end = lvl_last[sel];

endmodule

`default_nettype wire

// ===== verif/tb_pixel_mode_downscale_2x2.sv =====
// Self-checking testbench for the cascaded 2x2 mode downscaler.
module tb_pixel_mode_downscale_2x2;
	timeunit 1ns;
	timeprecision 1ps;

	import pmd2_pkg::*;

	localparam int LINE_DEPTH     = 2 * DEF_MAX_WIDTH;
	localparam int SETTLE_CYCLES  = 12;
	localparam int STUCK_LIMIT    = 1000;
	localparam int RANDOM_PIXELS  = 330;
	localparam int REPORT_LIMIT   = 10;

	localparam logic [CFG_IDX_W-1:0] REG_SPARE = CFG_IDX_W'(3);

	typedef enum logic [1:0] {
		JOB_PIXEL,
		JOB_CONFIG,
		JOB_DRAIN
	} job_kind_t;

	typedef struct {
		job_kind_t               kind;
		pixel_t                  pixel;
		logic [CFG_IDX_W-1:0]    index;
		logic [CFG_DATA_W-1:0]   data;
	} job_t;

	typedef struct packed {
		pixel_t pixel;
		logic   last;
	} downscaled_t;

	// DUT ports, inputs driven to known values from time zero
	logic                    clk       = 1'b0;
	logic                    arst_n    = 1'b0;
	logic                    cfg_valid = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_W-1:0]    cfg_index = '0;
	logic [CFG_DATA_W-1:0]   cfg_data  = '0;
	logic                    in_valid  = 1'b0;
	logic                    in_ready;
	pixel_t                  pixel_in  = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b1;
	pixel_t                  pixel_out;
	logic                    frame_end;

	// Predictor state: register copies and per-level raster positions
	logic [SRC_W_W-1:0]      width_reg  = RST_SOURCE_WIDTH;
	logic [SRC_H_W-1:0]      height_reg = RST_SOURCE_HEIGHT;
	logic [LVL_CNT_W-1:0]    levels_reg = RST_LEVEL_COUNT;
	pixel_t                  line_mem [LINE_DEPTH];
	pixel_t                  left_px [DEF_MAX_LEVELS];
	int unsigned             col_pos [DEF_MAX_LEVELS];
	int unsigned             row_pos [DEF_MAX_LEVELS];
	downscaled_t             downscaled_q [$];

	// Stimulus bookkeeping
	job_t                    job_q [$];
	job_t                    cur_job;
	bit                      job_open     = 1'b0;
	int unsigned             job_wait     = 0;
	int unsigned             jobs_total   = 0;
	int unsigned             jobs_retired = 0;
	int unsigned             jobs_fetched = 0;
	int unsigned             idle_run     = 0;
	bit                      send_calm    = 1'b0;
	bit                      recv_calm    = 1'b0;
	bit                      drv_in_v;
	bit                      drv_cfg_v;
	int unsigned             recv_stall   = 0;
	pixel_t                  palette [3];
	int unsigned             random_pixels = 0;
	int unsigned             settings_used = 0;

	// Scoreboard counters
	int unsigned             pixels_sent   = 0;
	int unsigned             results_seen  = 0;
	int unsigned             regs_written  = 0;
	int unsigned             errors        = 0;
	int unsigned             stuck_cycles  = 0;

	pixel_mode_downscale_2x2 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.pixel_in  (pixel_in),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.pixel_out (pixel_out),
		.frame_end (frame_end)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Earliest pixel that repeats later in the block wins, else bottom-right
	function automatic pixel_t block_mode(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
		pixel_t quad [4];
		quad = '{a, b, c, d};
		for (int i = 0; i < 3; i++) begin
			for (int j = i + 1; j < 4; j++) begin
				if (quad[i] == quad[j]) begin
					return quad[i];
				end
			end
		end
		return d;
	endfunction

	// Push one source pixel through the configured levels; queue the final level's result
	function automatic void downscale_pixel(pixel_t px);
		int unsigned w, h, levels, col, row, base, pw, ph;
		pixel_t cur;
		pixel_t res;
		downscaled_t item;
		w = (width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg;
		h = (height_reg > MAX_HEIGHT) ? MAX_HEIGHT : height_reg;
		levels = (levels_reg == 0) ? 1 :
			(levels_reg > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : levels_reg;
		cur = px;
		for (int lvl = 0; lvl < levels; lvl++) begin
			col  = col_pos[lvl];
			row  = row_pos[lvl];
			base = LINE_DEPTH - (LINE_DEPTH >> lvl);
			pw   = w / 2;
			ph   = h / 2;
			// advance raster position, wrapping at the end of the level's frame
			if (col + 1 >= w) begin
				col_pos[lvl] = 0;
				row_pos[lvl] = (row + 1 >= h) ? 0 : row + 1;
			end else begin
				col_pos[lvl] = col + 1;
			end
			// drop odd trailing column and row
			if (col >= 2 * pw || row >= 2 * ph) begin
				return;
			end
			if (row % 2 == 0) begin
				line_mem[base + col] = cur;
				return;
			end
			if (col % 2 == 0) begin
				left_px[lvl] = cur;
				return;
			end
			res = block_mode(line_mem[base + col - 1], line_mem[base + col], left_px[lvl], cur);
			if (lvl + 1 == levels) begin
				item.pixel = res;
				item.last  = (col / 2 + 1 == pw) && (row / 2 + 1 == ph);
				downscaled_q.push_back(item);
				return;
			end
			cur = res;
			w   = pw;
			h   = ph;
		end
	endfunction

	// Register write; known indexes restart the frame on every level
	function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		case (idx)
			REG_SOURCE_WIDTH: begin
				width_reg = data[SRC_W_W-1:0];
			end
			REG_SOURCE_HEIGHT: begin
				height_reg = data[SRC_H_W-1:0];
			end
			REG_LEVEL_COUNT: begin
				levels_reg = data[LVL_CNT_W-1:0];
			end
			default: begin
				return;
			end
		endcase
		for (int i = 0; i < DEF_MAX_LEVELS; i++) begin
			col_pos[i] = 0;
			row_pos[i] = 0;
		end
	endfunction

	function automatic int unsigned draw_wait(bit calm);
		return calm ? 0 : $urandom_range(0, 10);
	endfunction

	function automatic void flag_error(string msg);
		errors++;
		if (errors <= REPORT_LIMIT) begin
			$display("[%0t] mismatch: %s", $realtime, msg);
		end
	endfunction

	// Job queue fillers
	function automatic void queue_pixel(pixel_t px);
		job_t j;
		j.kind  = JOB_PIXEL;
		j.pixel = px;
		j.index = '0;
		j.data  = '0;
		job_q.push_back(j);
		jobs_total++;
	endfunction

	function automatic void queue_register(logic [CFG_IDX_W-1:0] idx,
		logic [CFG_DATA_W-1:0] data);
		job_t j;
		j.kind  = JOB_CONFIG;
		j.pixel = '0;
		j.index = idx;
		j.data  = data;
		job_q.push_back(j);
		jobs_total++;
	endfunction

	function automatic void queue_drain();
		job_t j;
		j.kind  = JOB_DRAIN;
		j.pixel = '0;
		j.index = '0;
		j.data  = '0;
		job_q.push_back(j);
		jobs_total++;
	endfunction

	function automatic void queue_setting(int unsigned w, int unsigned h, int unsigned lv);
		queue_register(REG_SOURCE_WIDTH, CFG_DATA_W'(w));
		queue_register(REG_SOURCE_HEIGHT, CFG_DATA_W'(h));
		queue_register(REG_LEVEL_COUNT, CFG_DATA_W'(lv));
		settings_used++;
	endfunction

	function automatic void queue_block(pixel_t a, pixel_t b, pixel_t c, pixel_t d);
		queue_pixel(a);
		queue_pixel(b);
		queue_pixel(c);
		queue_pixel(d);
	endfunction

	// Mostly palette colors so that ties happen, some fully random values
	function automatic pixel_t draw_pixel();
		if ($urandom_range(0, 3) == 0) begin
			return pixel_t'($urandom_range(0, 65535));
		end
		return palette[$urandom_range(0, 2)];
	endfunction

	function automatic void refresh_palette();
		for (int i = 0; i < 3; i++) begin
			palette[i] = pixel_t'($urandom_range(0, 65535));
		end
	endfunction

	function automatic void queue_pixels(int unsigned n, bit counted);
		for (int unsigned i = 0; i < n; i++) begin
			if ($urandom_range(0, 149) == 0) begin
				queue_drain();
			end
			queue_pixel(draw_pixel());
		end
		if (counted) begin
			random_pixels += n;
		end
	endfunction

	// One random setting followed by a stream of pixels under it
	function automatic void queue_random_phase();
		int unsigned r, lv_raw, lv, dim, w, h, frames, n;
		r = $urandom_range(0, 15);
		lv_raw = (r == 0) ? 0 : (r <= 7) ? 1 : (r <= 11) ? 2 : (r <= 13) ? 3 :
			(r == 14) ? 4 : $urandom_range(5, 7);
		lv = (lv_raw == 0) ? 1 : (lv_raw > DEF_MAX_LEVELS) ? DEF_MAX_LEVELS : lv_raw;
		dim = 1 << lv;
		if ($urandom_range(0, 7) == 0) begin
			// often too small for the final level to produce anything
			w = $urandom_range(2, dim + 1);
			h = $urandom_range(2, dim + 1);
		end else begin
			w = $urandom_range(dim, dim + ((lv <= 2) ? 6 : 3));
			h = $urandom_range(dim, dim + ((lv <= 2) ? 6 : 3));
		end
		frames = (lv >= 3) ? 1 : $urandom_range(1, 3);
		n = frames * w * h + $urandom_range(0, w);
		if (n > 600) begin
			n = 600;
		end
		// keep the pixel total within the budget
		if (n > RANDOM_PIXELS - random_pixels) begin
			n = RANDOM_PIXELS - random_pixels;
		end
		refresh_palette();
		queue_setting(w, h, lv_raw);
		queue_pixels(n, 1'b1);
	endfunction

	// Driver: retire accepted transactions, then start the next job
	always @(posedge clk) begin
		drv_in_v  = in_valid;
		drv_cfg_v = cfg_valid;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				drv_in_v = 1'b0;
				pixels_sent++;
				jobs_retired++;
			end
			if (cfg_valid && cfg_ready) begin
				drv_cfg_v = 1'b0;
				regs_written++;
				jobs_retired++;
			end
			// count cycles with nothing outstanding anywhere
			if (in_valid || cfg_valid || downscaled_q.size() != 0) begin
				idle_run = 0;
			end else begin
				idle_run++;
			end
			if (!drv_in_v && !drv_cfg_v && !job_open && job_q.size() != 0) begin
				cur_job  = job_q.pop_front();
				job_open = 1'b1;
				job_wait = draw_wait(send_calm);
				jobs_fetched++;
				if (jobs_fetched % 50 == 0) begin
					send_calm = ($urandom_range(0, 3) == 0);
				end
			end
			if (job_open && !drv_in_v && !drv_cfg_v) begin
				case (cur_job.kind)
					JOB_PIXEL: begin
						if (job_wait == 0) begin
							drv_in_v = 1'b1;
							pixel_in <= cur_job.pixel;
							job_open = 1'b0;
						end else begin
							job_wait--;
						end
					end
					JOB_CONFIG: begin
						if (idle_run >= SETTLE_CYCLES) begin
							drv_cfg_v = 1'b1;
							cfg_index <= cur_job.index;
							cfg_data  <= cur_job.data;
							job_open  = 1'b0;
						end
					end
					default: begin
						// hold off until every pending result is out
						if (idle_run >= 2) begin
							job_open = 1'b0;
							jobs_retired++;
						end
					end
				endcase
			end
		end
		in_valid  <= drv_in_v;
		cfg_valid <= drv_cfg_v;
	end

	// Monitor: predict on accepted inputs, check accepted results, stall the output
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				results_seen++;
				if (downscaled_q.size() == 0) begin
					flag_error($sformatf("unexpected result pixel=%h frame_end=%b",
						pixel_out, frame_end));
				end else begin
					if (pixel_out !== downscaled_q[0].pixel ||
						frame_end !== downscaled_q[0].last) begin
						flag_error($sformatf("result %0d: expected pixel=%h frame_end=%b, got pixel=%h frame_end=%b",
							results_seen, downscaled_q[0].pixel, downscaled_q[0].last,
							pixel_out, frame_end));
					end
					void'(downscaled_q.pop_front());
				end
				if (results_seen % 40 == 0) begin
					recv_calm = ($urandom_range(0, 3) == 0);
				end
				recv_stall = draw_wait(recv_calm);
				if (recv_stall != 0) begin
					out_ready <= 1'b0;
				end
			end else if (!out_ready) begin
				recv_stall--;
				if (recv_stall == 0) begin
					out_ready <= 1'b1;
				end
			end
			if (cfg_valid && cfg_ready) begin
				write_register(cfg_index, cfg_data);
			end
			if (in_valid && in_ready) begin
				downscale_pixel(pixel_in);
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			stuck_cycles <= 0;
		end else if (stuck_cycles + 1 >= STUCK_LIMIT) begin
			$display("timeout: no transaction for %0d cycles, %0d results outstanding",
				STUCK_LIMIT, downscaled_q.size());
			$display("CHECK FAILED");
			$finish;
		end else begin
			stuck_cycles <= stuck_cycles + 1;
		end
	end

	// Stimulus plan, reset and end of run
	initial begin
		// directed: one block per frame, one per tie-break branch
		queue_setting(2, 2, 1);
		queue_block(16'h0000, 16'hFFFF, 16'h1234, 16'h0000);
		queue_drain();
		queue_block(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0001);
		// unknown register index between row halves must not restart the frame
		queue_pixel(16'h0005);
		queue_pixel(16'h0006);
		queue_register(REG_SPARE, CFG_DATA_W'($urandom_range(0, 8191)));
		queue_pixel(16'h0005);
		queue_pixel(16'h0007);
		queue_block(16'h0001, 16'h0002, 16'h0003, 16'h0002);
		queue_block(16'h0001, 16'h0002, 16'h0002, 16'h0003);
		queue_block(16'h0001, 16'h0002, 16'h0003, 16'h0003);
		queue_block(16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF);

		// widest row, exact or above the maximum
		refresh_palette();
		queue_setting(($urandom_range(0, 1) == 0) ? DEF_MAX_WIDTH : $urandom_range(1025, 2047),
			2, 1);
		queue_pixels(DEF_MAX_WIDTH + 8, 1'b0);

		// tallest frame, exact or above the maximum
		refresh_palette();
		queue_setting(2, ($urandom_range(0, 1) == 0) ? MAX_HEIGHT : $urandom_range(4097, 8191), 1);
		queue_pixels(64, 1'b0);

		// random settings until the pixel budget is spent
		while (random_pixels < RANDOM_PIXELS) begin
			queue_random_phase();
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (jobs_retired != jobs_total) begin
			@(posedge clk);
		end
		@(posedge clk);
		while (downscaled_q.size() != 0) begin
			@(posedge clk);
		end
		repeat (2 * SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d pixels in, %0d results checked, %0d register writes, %0d settings",
			pixels_sent, results_seen, regs_written, settings_used);
		$display("run: %0d mismatches", errors);
		if (errors == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
